[rtl/spq_pkg.sv]
package spq_pkg;

   // Default sizes
   localparam int DEPTH_DEF     = 16;
   localparam int TAG_BITS_DEF  = 8;
   localparam int PRIO_BITS_DEF = 3;

   // Width of the occupancy field of a result beat
   localparam int OCC_BITS = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

endpackage

[rtl/spq_if.sv]
// Request channel: one insert or pop per beat
interface spq_req_if #(
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   spq_pkg::opcode_type    opcode;
   logic [TAG_BITS-1:0]    entry_tag;
   logic [PRIO_BITS-1:0]   priority_req;

   modport source (output valid, output opcode, output entry_tag, output priority_req,
                   input ready);
   modport sink   (input valid, input opcode, input entry_tag, input priority_req,
                   output ready);
endinterface

// Response channel: one result per request beat
interface spq_rsp_if #(
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   spq_pkg::status_type            status;
   logic [TAG_BITS-1:0]            popped_tag;
   logic [PRIO_BITS-1:0]           popped_priority;
   logic [spq_pkg::OCC_BITS-1:0]   occupancy;

   modport source (output valid, output status, output popped_tag, output popped_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input popped_tag, input popped_priority,
                   input occupancy, output ready);
endinterface

[rtl/spq_ram.sv]
module spq_ram #(
   parameter int WIDTH = spq_pkg::TAG_BITS_DEF,
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   import spq_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry; read returns the old contents on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/stable_priority_queue.sv]
// Channel  Dir  Beat fields                                     Accepted when
// req_ch   in   opcode, entry_tag, priority_req                 valid && ready
// rsp_ch   out  status, popped_tag, popped_priority, occupancy  valid && ready
//
// Each request passes S_IDLE, which accepts it and issues the RAM accesses,
// then S_FINISH, which uses the registered RAM data to update the level lists.
// Entries live in a tag RAM and a link RAM as one linked list per priority.
// Reset clears the control state only; the RAMs are not cleared.
// A response waiting on rsp_ch does not block the next request; the
// S_FINISH step of that request holds until the response register is free.
module stable_priority_queue #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEF,
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   localparam int IW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int LEVELS = 2 ** PRIO_BITS;

   typedef enum logic {
      S_IDLE,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   status_type           status_ff, status_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [IW-1:0]        node_ff, node_in;
   logic                 from_free_ff, from_free_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        fresh_ff, fresh_in;
   logic [IW-1:0]        free_head_ff, free_head_in;
   logic [IW-1:0]        head_ff [LEVELS];
   logic [IW-1:0]        head_in [LEVELS];
   logic [IW-1:0]        tail_ff [LEVELS];
   logic [IW-1:0]        tail_in [LEVELS];
   logic [LEVELS-1:0]    busy_ff, busy_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [PRIO_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [OCC_BITS-1:0]  rsp_occ_ff, rsp_occ_in;

   logic [PRIO_BITS-1:0] top_level;
   logic                 any_busy;
   logic                 is_full;
   logic                 use_fresh;
   logic [IW-1:0]        new_node;
   logic                 out_free;
   logic                 accept;
   logic                 do_insert;
   logic                 do_pop;

   logic                 tag_we, tag_re;
   logic [IW-1:0]        tag_wa, tag_ra;
   logic [TAG_BITS-1:0]  tag_rd;
   logic                 link_we, link_re;
   logic [IW-1:0]        link_wa, link_ra, link_wd;
   logic [IW-1:0]        link_rd;

   // Find the highest nonempty priority level
   always_comb begin
      top_level = '0;
      any_busy  = |busy_ff;
      for (int i = 0; i < LEVELS; i++) begin
         if (busy_ff[i]) begin
            top_level = PRIO_BITS'(i);
         end
      end
   end

   // Decode the request and pick a node to allocate
   assign is_full   = (count_ff == CW'(DEPTH));
   assign use_fresh = (fresh_ff != CW'(DEPTH));
   assign new_node  = use_fresh ? fresh_ff[IW-1:0] : free_head_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = (state_ff == S_IDLE) && req_ch.valid;
   assign do_insert = accept && (req_ch.opcode == OP_INSERT) && !is_full;
   assign do_pop    = accept && (req_ch.opcode == OP_POP) && any_busy;

   // Tag RAM: write the new tag, read the head tag on a pop
   assign tag_we = do_insert;
   assign tag_wa = new_node;
   assign tag_re = do_pop;
   assign tag_ra = head_ff[top_level];

   // Link RAM: chain the new node behind its level tail, or push the popped
   // head onto the free list while reading its successor
   always_comb begin
      link_we = 1'b0;
      link_wa = head_ff[top_level];
      link_wd = free_head_ff;
      link_re = 1'b0;
      link_ra = head_ff[top_level];
      if (do_insert) begin
         link_we = busy_ff[req_ch.priority_req];
         link_wa = tail_ff[req_ch.priority_req];
         link_wd = new_node;
         link_re = !use_fresh;
         link_ra = free_head_ff;
      end else if (do_pop) begin
         link_we = 1'b1;
         link_re = 1'b1;
      end
   end

   spq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (req_ch.entry_tag),
      .rd_en   (tag_re),
      .rd_addr (tag_ra),
      .rd_data (tag_rd)
   );

   spq_ram #(
      .WIDTH (IW),
      .DEPTH (DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // Sequence one request: issue, then commit and post the response
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      prio_in       = prio_ff;
      node_in       = node_ff;
      from_free_in  = from_free_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      free_head_in  = free_head_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in     = S_FINISH;
               from_free_in = !use_fresh;
               if (req_ch.opcode == OP_POP) begin
                  prio_in   = top_level;
                  node_in   = head_ff[top_level];
                  status_in = any_busy ? ST_POPPED : ST_EMPTY;
               end else begin
                  prio_in   = req_ch.priority_req;
                  node_in   = new_node;
                  status_in = is_full ? ST_FULL : ST_INSERTED;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_tag_in    = '0;
               rsp_prio_in   = '0;
               unique case (status_ff)
                  ST_INSERTED: begin
                     if (!busy_ff[prio_ff]) begin
                        head_in[prio_ff] = node_ff;
                     end
                     tail_in[prio_ff] = node_ff;
                     busy_in[prio_ff] = 1'b1;
                     count_in         = count_ff + CW'(1);
                     if (from_free_ff) begin
                        free_head_in = link_rd;
                     end else begin
                        fresh_in = fresh_ff + CW'(1);
                     end
                  end
                  ST_POPPED: begin
                     if (node_ff == tail_ff[prio_ff]) begin
                        busy_in[prio_ff] = 1'b0;
                     end else begin
                        head_in[prio_ff] = link_rd;
                     end
                     free_head_in = node_ff;
                     count_in     = count_ff - CW'(1);
                     rsp_tag_in   = tag_rd;
                     rsp_prio_in  = prio_ff;
                  end
                  default: begin
                  end
               endcase
               rsp_occ_in = OCC_BITS'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         busy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         busy_ff      <= busy_in;
      end
      status_ff     <= status_in;
      prio_ff       <= prio_in;
      node_ff       <= node_in;
      from_free_ff  <= from_free_in;
      free_head_ff  <= free_head_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Drive the channels
   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.popped_tag      = rsp_tag_ff;
   assign rsp_ch.popped_priority = rsp_prio_ff;
   assign rsp_ch.occupancy       = rsp_occ_ff;

endmodule

[verif/tb.sv]
module tb;
   import spq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int TB          = TAG_BITS_DEF;
   localparam int PB          = PRIO_BITS_DEF;
   localparam int RAND_ITEMS  = 600;
   localparam int QUIET_TAIL  = 100;
   localparam int STALL_LIMIT = 400;

   typedef struct {
      status_type      status;
      logic [TB-1:0]   tag;
      logic [PB-1:0]   prio;
      logic [OCC_BITS-1:0] occ;
   } outcome_type;

   typedef struct {
      opcode_type    op;
      logic [TB-1:0] tag;
      logic [PB-1:0] prio;
      bit            typed;
      outcome_type   want;
   } stim_row_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow of the queue contents, head at index 0
   logic [TB-1:0] shadow_tag  [DEPTH];
   logic [PB-1:0] shadow_prio [DEPTH];
   int            shadow_count;

   outcome_type  due_results [$];
   stim_row_type plan [$];
   int           mismatch_count;
   int           stall_cycles;
   int           idle_pct;
   bit           quiet;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one request to the shadow queue and return the result it gives
   function automatic outcome_type shadow_apply(opcode_type op, logic [TB-1:0] tag,
                                                logic [PB-1:0] prio);
      outcome_type r;
      int          pos;
      int          i;
      r.status = ST_INSERTED;
      r.tag    = '0;
      r.prio   = '0;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // place after every entry of equal or higher priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_tag[i]  = shadow_tag[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_tag[pos]  = tag;
            shadow_prio[pos] = prio;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.status = ST_POPPED;
         r.tag    = shadow_tag[0];
         r.prio   = shadow_prio[0];
         for (i = 1; i < shadow_count; i++) begin
            shadow_tag[i-1]  = shadow_tag[i];
            shadow_prio[i-1] = shadow_prio[i];
         end
         shadow_count--;
      end
      r.occ = shadow_count[OCC_BITS-1:0];
      return r;
   endfunction

   task automatic add_row(opcode_type op, logic [TB-1:0] tag, logic [PB-1:0] prio,
                          bit typed, status_type st, logic [TB-1:0] ptag,
                          logic [PB-1:0] pprio, logic [OCC_BITS-1:0] occ);
      stim_row_type row;
      row.op          = op;
      row.tag         = tag;
      row.prio        = prio;
      row.typed       = typed;
      row.want.status = st;
      row.want.tag    = ptag;
      row.want.prio   = pprio;
      row.want.occ    = occ;
      plan.push_back(row);
   endtask

   // Drop valid for a burst of cycles
   task automatic sender_rest(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one beat, hold it until accepted, then log the expected result
   task automatic send_beat(stim_row_type row);
      outcome_type pred;
      if (!quiet && $urandom_range(0, 99) < idle_pct)
         sender_rest($urandom_range(1, 16));
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= row.op;
      req_ch.entry_tag    <= row.tag;
      req_ch.priority_req <= row.prio;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = shadow_apply(row.op, row.tag, row.prio);
      due_results.push_back(row.typed ? row.want : pred);
   endtask

   // Stimulus
   initial begin
      stim_row_type row;
      int           i;
      int           ins_pct;
      int           prio_top;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_INSERT;
      req_ch.entry_tag    <= '0;
      req_ch.priority_req <= '0;
      quiet          = 1'b0;
      idle_pct       = 30;
      shadow_count   = 0;
      mismatch_count = 0;

      // pop on empty, extremes, ties kept in arrival order
      add_row(OP_POP,    8'h00, 3'd0, 1, ST_EMPTY,    8'h00, 3'd0, 5'd0);
      add_row(OP_INSERT, 8'h00, 3'd0, 1, ST_INSERTED, 8'h00, 3'd0, 5'd1);
      add_row(OP_INSERT, 8'hFF, 3'd7, 1, ST_INSERTED, 8'h00, 3'd0, 5'd2);
      add_row(OP_INSERT, 8'h55, 3'd7, 1, ST_INSERTED, 8'h00, 3'd0, 5'd3);
      add_row(OP_POP,    8'h00, 3'd0, 1, ST_POPPED,   8'hFF, 3'd7, 5'd2);
      add_row(OP_POP,    8'hFF, 3'd7, 1, ST_POPPED,   8'h55, 3'd7, 5'd1);
      // fill to the brim, then one insert too many
      for (i = 1; i < DEPTH; i++)
         add_row(OP_INSERT, 8'hA0 ^ i[7:0], i[2:0], 0, ST_INSERTED, '0, '0, '0);
      add_row(OP_INSERT, 8'h3C, 3'd5, 1, ST_FULL, 8'h00, 3'd0, DEPTH[OCC_BITS-1:0]);
      add_row(OP_POP,    8'h00, 3'd0, 0, ST_POPPED, '0, '0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) send_beat(plan[k]);

      // random part in segments of differing insert bias, priority spread and idling
      ins_pct  = 50;
      prio_top = 7;
      for (i = 0; i < RAND_ITEMS; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 3))
               0: ins_pct = 20;
               1: ins_pct = 50;
               2: ins_pct = 80;
               default: ins_pct = 95;
            endcase
            prio_top = ($urandom_range(0, 2) == 0) ? 1 : 7;
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         end
         if (i == RAND_ITEMS / 2) begin
            // hold off until the queue of results has drained
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (due_results.size() != 0);
         end
         if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
         row.op    = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
         row.tag   = TB'($urandom_range(0, 255));
         row.prio  = PB'($urandom_range(0, prio_top));
         row.typed = 1'b0;
         send_beat(row);
      end

      // drain and let the block settle
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Result sink: ready in random bursts, steady high at the tail
   initial begin
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: result beat with nothing pending, status %0d", rsp_ch.status);
         end else begin
            want = due_results.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.popped_tag !== want.tag ||
                rsp_ch.popped_priority !== want.prio || rsp_ch.occupancy !== want.occ) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: mismatch want st %0d tag %02h prio %0d occ %0d",
                           want.status, want.tag, want.prio, want.occ);
                  $display("tb:          got  st %0d tag %02h prio %0d occ %0d",
                           rsp_ch.status, rsp_ch.popped_tag, rsp_ch.popped_priority,
                           rsp_ch.occupancy);
               end
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial stall_cycles = 0;

endmodule

[files.f]
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ram.sv
rtl/stable_priority_queue.sv
verif/tb.sv
